FILE: sv/mrp_pkg.sv
`default_nettype none
package mrp_pkg;

	// candidate and random words
	localparam int unsigned NUMBER_WIDTH = 32;
	localparam int unsigned MAX_ROUNDS   = 4;
	localparam int unsigned WORD_COUNT   = 4;
	localparam int unsigned BIT_W        = $clog2(NUMBER_WIDTH);
	localparam int unsigned RND_W        = 3;
	localparam int unsigned WIDX_W       = $clog2(WORD_COUNT);
	localparam logic [RND_W-1:0] ROUNDS_RESET = RND_W'(4);

	// bounded round limit: smaller of MAX_ROUNDS and WORD_COUNT
	localparam int unsigned ROUND_CAP = (MAX_ROUNDS < WORD_COUNT) ? MAX_ROUNDS : WORD_COUNT;

	typedef logic [NUMBER_WIDTH-1:0] num_t;

	// request to the modular multiplier
	typedef struct packed {
		logic start;
		num_t a;
		num_t b;
		num_t m;
	} mm_req_t;

	// multiplier status
	typedef struct packed {
		logic busy;
		logic done;
	} mm_st_t;

endpackage
`default_nettype wire

FILE: sv/mrp_modmul.sv
`default_nettype none
// Bit-serial modular multiplier: r = a * b mod m, one bit of a per cycle,
// MSB first. Needs b < 2m - (m-1) and yields r < m.
module mrp_modmul
	import mrp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire mm_req_t req,
	output mm_st_t       st,
	output num_t         r
);

	num_t             a_q;
	num_t             b_q;
	num_t             m_q;
	num_t             r_q;
	logic [BIT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [NUMBER_WIDTH:0] dbl;
	logic [NUMBER_WIDTH:0] dbl_red;
	logic [NUMBER_WIDTH:0] sum;
	logic [NUMBER_WIDTH:0] sum_red;

	// one interleaved step: double, reduce, add, reduce
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum     = dbl_red + {1'b0, (a_q[NUMBER_WIDTH-1] ? b_q : '0)};
		sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= BIT_W'(NUMBER_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == '0);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[NUMBER_WIDTH-2:0], 1'b0};
			r_q <= sum_red[NUMBER_WIDTH-1:0];
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign r       = r_q;

endmodule
`default_nettype wire

FILE: sv/miller_rabin_primality_test_core.sv
`default_nettype none
// Miller-Rabin probable-prime tester. One candidate and four random words go in
// per transaction; one flag (probably_prime) comes out. Values below 2 and even
// values other than 2 go from idle straight to the finish state, which loads the
// result into the output register once that register is free. Otherwise the
// block strips factors of two from candidate-1 (one bit per cycle), then runs up
// to rounds_used rounds, capped at ROUND_CAP, on a single bit-serial modular
// multiplier. A round costs one reduction for the base, NUMBER_WIDTH squarings
// plus one multiply per set bit of the odd part for the exponentiation, and up
// to d-1 further squarings: at most about 64 products per round.
// A new candidate is taken only while the engine is idle; a finished result
// sits in an output register and does not block the next transaction.
// rounds_used (reset 4) is to be written by the user through cfg_* only while
// the block is idle; the block itself does not enforce this.
module miller_rabin_primality_test_core
	import mrp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire num_t             candidate,
	input  wire num_t             random_word_0,
	input  wire num_t             random_word_1,
	input  wire num_t             random_word_2,
	input  wire num_t             random_word_3,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  probably_prime,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [RND_W-1:0] cfg_data
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SPLIT = 9'b000000010,
		S_ROUND = 9'b000000100,
		S_POW   = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_ADV   = 9'b000100000,
		S_CHECK = 9'b001000000,
		S_LOOP  = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	typedef enum logic [3:0] {
		OP_BASE = 4'b0001,
		OP_PSQ  = 4'b0010,
		OP_PMUL = 4'b0100,
		OP_LSQ  = 4'b1000
	} op_t;

	state_t           state_q;
	op_t              op_q;
	logic [RND_W-1:0] rounds_q;
	logic [RND_W-1:0] lim_q;
	logic [RND_W-1:0] round_q;
	num_t             p_q;
	num_t             s_q;
	num_t             a_q;
	num_t             acc_q;
	num_t             words_q [WORD_COUNT];
	logic [BIT_W-1:0] d_q;
	logic [BIT_W-1:0] bit_q;
	logic [BIT_W-1:0] rcnt_q;
	logic             res_q;
	logic             out_valid_q;
	logic             out_q;

	num_t    pm1;
	mm_req_t mm_req;
	mm_st_t  mm_st;
	num_t    mm_r;
	logic    in_acc;
	logic    out_free;

	assign pm1      = p_q - 1'b1;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall       = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign probably_prime = out_q;

	mrp_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.st     (mm_st),
		.r      (mm_r)
	);

	// multiplier requests
	always_comb begin
		mm_req       = '0;
		mm_req.m     = p_q;
		unique case (state_q)
			S_ROUND: begin
				if (round_q != lim_q) begin
					mm_req.start = 1'b1;
					mm_req.a     = words_q[round_q[WIDX_W-1:0]];
					mm_req.b     = num_t'(1);
					mm_req.m     = pm1;
				end
			end
			S_POW: begin
				mm_req.start = 1'b1;
				mm_req.a     = acc_q;
				mm_req.b     = acc_q;
			end
			S_LOOP: begin
				if (rcnt_q < d_q) begin
					mm_req.start = 1'b1;
					mm_req.a     = acc_q;
					mm_req.b     = acc_q;
				end
			end
			S_MUL: begin
				if (mm_st.done && op_q == OP_PSQ && s_q[bit_q]) begin
					mm_req.start = 1'b1;
					mm_req.a     = mm_r;
					mm_req.b     = a_q;
				end
			end
			default: ;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= ROUNDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rounds_q <= cfg_data;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_BASE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (candidate < num_t'(2) || (candidate != num_t'(2) && !candidate[0])) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SPLIT;
						end
					end
				end
				S_SPLIT: begin
					if (s_q[0]) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (round_q == lim_q) begin
						state_q <= S_FIN;
					end else begin
						op_q    <= OP_BASE;
						state_q <= S_MUL;
					end
				end
				S_POW: begin
					op_q    <= OP_PSQ;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mm_st.done) begin
						unique case (op_q)
							OP_BASE: state_q <= S_POW;
							OP_PSQ: begin
								if (s_q[bit_q]) begin
									op_q <= OP_PMUL;
								end else begin
									state_q <= S_ADV;
								end
							end
							OP_PMUL: state_q <= S_ADV;
							OP_LSQ: begin
								if (mm_r == pm1) begin
									state_q <= S_ROUND;
								end else if (mm_r == num_t'(1)) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_LOOP;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADV: begin
					state_q <= (bit_q == '0) ? S_CHECK : S_POW;
				end
				S_CHECK: begin
					state_q <= (acc_q == num_t'(1) || acc_q == pm1) ? S_ROUND : S_LOOP;
				end
				S_LOOP: begin
					if (rcnt_q < d_q) begin
						op_q    <= OP_LSQ;
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					p_q        <= candidate;
					s_q        <= candidate - 1'b1;
					d_q        <= '0;
					round_q    <= '0;
					res_q      <= 1'b0;
					words_q[0] <= random_word_0;
					words_q[1] <= random_word_1;
					words_q[2] <= random_word_2;
					words_q[3] <= random_word_3;
					lim_q      <= (rounds_q > RND_W'(ROUND_CAP)) ? RND_W'(ROUND_CAP) : rounds_q;
				end
			end
			S_SPLIT: begin
				if (!s_q[0]) begin
					s_q <= s_q >> 1;
					d_q <= d_q + 1'b1;
				end
			end
			S_ROUND: begin
				if (round_q == lim_q) begin
					res_q <= 1'b1;
				end
			end
			S_MUL: begin
				if (mm_st.done) begin
					unique case (op_q)
						OP_BASE: begin
							a_q   <= mm_r + 1'b1;
							acc_q <= num_t'(1);
							bit_q <= BIT_W'(NUMBER_WIDTH - 1);
						end
						OP_PSQ:  acc_q <= mm_r;
						OP_PMUL: acc_q <= mm_r;
						OP_LSQ: begin
							acc_q  <= mm_r;
							rcnt_q <= rcnt_q + 1'b1;
							if (mm_r == pm1) begin
								round_q <= round_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_ADV: begin
				if (bit_q != '0) begin
					bit_q <= bit_q - 1'b1;
				end
			end
			S_CHECK: begin
				rcnt_q <= BIT_W'(1);
				if (acc_q == num_t'(1) || acc_q == pm1) begin
					round_q <= round_q + 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mm_st.done |-> state_q == S_MUL)
		else $error("multiplier finished outside a wait state");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> acc_q < p_q)
		else $error("exponent result not reduced");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("accepted transaction not started");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |-> !mm_st.busy)
		else $error("multiplier restarted while busy");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/miller_rabin_primality_test_core_tb.sv
`default_nettype none
module miller_rabin_primality_test_core_tb
	import mrp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64_t;

	// one candidate and its four base words
	typedef struct {
		num_t cand;
		num_t w [WORD_COUNT];
	} prime_query_t;

	// directed row: verdict of -1 means ask the predictor
	typedef struct {
		num_t cand;
		num_t w [WORD_COUNT];
		int   verdict;
	} directed_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	num_t             candidate;
	num_t             random_word_0;
	num_t             random_word_1;
	num_t             random_word_2;
	num_t             random_word_3;
	logic             out_valid;
	logic             out_stall;
	logic             probably_prime;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [RND_W-1:0] cfg_data;

	miller_rabin_primality_test_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.candidate(candidate),
		.random_word_0(random_word_0), .random_word_1(random_word_1),
		.random_word_2(random_word_2), .random_word_3(random_word_3),
		.out_valid(out_valid), .out_stall(out_stall),
		.probably_prime(probably_prime),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor copy of the round register
	logic [RND_W-1:0] rounds_cfg;
	bit               verdicts_due [$];
	int               fails;
	int               n_verdicts;
	int               n_primes;
	int               n_rounds_set;
	bit               calm;
	bit               hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#300ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic u64_t mod_mul(u64_t a, u64_t b, u64_t m);
		return (a * b) % m;
	endfunction

	function automatic u64_t mod_pow(u64_t b, u64_t e, u64_t m);
		u64_t acc;
		acc = 1 % m;
		b = b % m;
		while (e > 0) begin
			if (e[0])
				acc = mod_mul(acc, b, m);
			e = e >> 1;
			b = mod_mul(b, b, m);
		end
		return acc;
	endfunction

	// full Miller-Rabin verdict for one candidate under the current round count
	function automatic bit prime_verdict(prime_query_t q, logic [RND_W-1:0] rnds);
		u64_t p, odd_part, pm1, x, base;
		int   twos, lim;
		bit   pass;
		p = q.cand;
		if (p < 2 || (p != 2 && !p[0]))
			return 1'b0;
		pm1 = p - 1;
		odd_part = pm1;
		twos = 0;
		while (!odd_part[0]) begin
			odd_part = odd_part >> 1;
			twos++;
		end
		lim = (rnds > ROUND_CAP) ? ROUND_CAP : rnds;
		for (int i = 0; i < lim; i++) begin
			base = (u64_t'(q.w[i]) % pm1) + 1;
			x = mod_pow(base, odd_part, p);
			pass = (x == 1 || x == pm1);
			for (int r = 1; r < twos && !pass; r++) begin
				x = mod_mul(x, x, p);
				if (x == pm1)
					pass = 1'b1;
				else if (x == 1)
					break;
			end
			if (!pass)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// configuration write at idle
	task automatic write_rounds(logic [RND_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		rounds_cfg = v;
		n_rounds_set++;
		cfg_valid <= 1'b0;
	endtask

	task automatic idle_sender();
		int n;
		if (!calm && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// present one transaction and log its expected verdict on acceptance
	task automatic send_query(prime_query_t q, int verdict);
		bit pred;
		idle_sender();
		in_valid      <= 1'b1;
		candidate     <= q.cand;
		random_word_0 <= q.w[0];
		random_word_1 <= q.w[1];
		random_word_2 <= q.w[2];
		random_word_3 <= q.w[3];
		do @(posedge clk); while (in_stall);
		pred = prime_verdict(q, rounds_cfg);
		if (verdict >= 0 && pred != verdict[0]) begin
			$error("table row cand=%0d: predictor %0b, table %0b", q.cand, pred,
				verdict[0]);
			fails++;
		end
		verdicts_due.push_back(verdict >= 0 ? verdict[0] : pred);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic prime_query_t random_query();
		prime_query_t q;
		num_t primes [7] = '{7, 13, 65537, 104729, 1000003, 2147483647, 32'hFFFFFFFB};
		num_t pseudo [5] = '{561, 1105, 2047, 25326001, 32'd3215031751};
		int   k;
		for (int i = 0; i < WORD_COUNT; i++)
			case ($urandom_range(0, 7))
				0: q.w[i] = '0;
				1: q.w[i] = '1;
				default: q.w[i] = $urandom;
			endcase
		k = $urandom_range(0, 99);
		if (k < 25)
			q.cand = primes[$urandom_range(0, 6)];
		else if (k < 40)
			q.cand = pseudo[$urandom_range(0, 4)];
		else if (k < 55)
			q.cand = num_t'($urandom_range(0, 1000)) | 1;
		else if (k < 85)
			q.cand = $urandom | 1;
		else if (k < 95)
			q.cand = $urandom & ~num_t'(1);
		else
			q.cand = $urandom_range(0, 4);
		return q;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				$error("unexpected transaction: probably_prime=%0b", probably_prime);
				fails++;
			end else begin
				bit want;
				want = verdicts_due.pop_front();
				if (probably_prime !== want) begin
					$error("probably_prime: expected %0b, actual %0b", want, probably_prime);
					fails++;
				end
				n_verdicts++;
				n_primes += want;
			end
		end
	end

	// receiver back-pressure
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (30000) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	initial begin
		directed_row_t rows [$];
		prime_query_t  q;
		logic [RND_W-1:0] phases [7] = '{0, 1, 7, 2, 3, 5, 4};
		fails = 0; n_verdicts = 0; n_primes = 0; n_rounds_set = 0;
		calm = 1'b0; hold_req = 1'b0;
		rounds_cfg = ROUNDS_RESET;
		in_valid = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
		candidate = '0;
		random_word_0 = '0; random_word_1 = '0; random_word_2 = '0; random_word_3 = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small values, even values, two, extremes, pseudoprimes
		rows = '{
			'{32'd0, '{0, 0, 0, 0}, 0},
			'{32'd1, '{'1, '1, '1, '1}, 0},
			'{32'd2, '{0, '1, 5, 9}, 1},
			'{32'd3, '{0, 1, '1, 2}, 1},
			'{32'd4, '{1, 2, 3, 4}, 0},
			'{32'hFFFFFFFE, '{'1, '1, '1, '1}, 0},
			'{32'hFFFFFFFF, '{0, 0, 0, 0}, -1},
			'{32'hFFFFFFFF, '{'1, 12345, 7, 99}, -1},
			'{32'hFFFFFFFB, '{0, '1, 32'h5555AAAA, 32'hAAAA5555}, 1},
			'{32'h7FFFFFFF, '{3, 17, '1, 0}, 1},
			'{32'd561, '{1, 2, 3, 4}, -1},
			'{32'd2047, '{1, 1, 1, 1}, -1},
			'{32'd2047, '{1, 2, 3, 4}, -1},
			'{32'd25326001, '{1, 2, 4, 1}, -1},
			'{32'd3215031751, '{1, 2, 4, 6}, -1},
			'{32'd65537, '{65535, 65536, 0, 1}, 1},
			'{32'd9, '{7, 0, 1, 2}, -1},
			'{32'd5, '{'1, '1, '1, '1}, 1}
		};
		foreach (rows[i]) begin
			q.cand = rows[i].cand;
			q.w = rows[i].w;
			send_query(q, rows[i].verdict);
		end
		drain();

		// random phases across round settings, long receiver hold in the first
		foreach (phases[ph]) begin
			write_rounds(phases[ph]);
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == $size(phases) - 1)
				calm = 1'b1;
			repeat (14) send_query(random_query(), -1);
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Checked %0d verdicts (%0d probable primes) over %0d round settings,",
			n_verdicts, n_primes, n_rounds_set + 1);
		$display("including screening, extremes, pseudoprimes and a long output hold.");
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
sv/mrp_pkg.sv
sv/mrp_modmul.sv
sv/miller_rabin_primality_test_core.sv
tb/sv/miller_rabin_primality_test_core_tb.sv
